// ===== src/packed_3bit_cell_store_core_macros.svh =====
// Assertion macros used by the checker file of the packed cell store.
`ifndef PACKED_3BIT_CELL_STORE_CORE_MACROS_SVH
`define PACKED_3BIT_CELL_STORE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PCS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pcs_pkg.sv =====
// Types and constants shared by the packed 3-bit cell store.
`timescale 1ns / 1ps
package pcs_pkg;

	localparam int ROW_W    = 6;
	localparam int COL_W    = 6;
	localparam int CNT_W    = 7;
	localparam int VAL_W    = 3;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 8'd1;

	localparam logic [CNT_W-1:0] ROW_COUNT_RST = 7'd8;
	localparam logic [CNT_W-1:0] COL_COUNT_RST = 7'd8;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic [VAL_W-1:0] CELL_MASK = 3'h7;
	// window of two bytes: cell at bit offset off sits at shift 13 - off
	localparam logic [3:0] WIN_TOP = 4'd13;
	// offsets above this one spill into the second byte
	localparam logic [2:0] LAST_ONE_BYTE_OFF = 3'd5;

	typedef struct packed {
		logic             oor;
		logic             action;
		logic [VAL_W-1:0] wval;
		logic [2:0]       off;
		logic             idx_odd;
		logic             lo_ok;
	} pcs_op_t;

endpackage

// ===== src/pcs_addr.sv =====
// Cell locator: range check and byte/bank addresses of one cell.
`timescale 1ns / 1ps
module pcs_addr import pcs_pkg::*; #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLS    = 64,
	parameter int STORE_BYTES = 1536,
	parameter int AW          = 10
) (
	input  logic [CNT_W-1:0] row_count,
	input  logic [CNT_W-1:0] col_count,
	input  logic             action,
	input  logic [ROW_W-1:0] row,
	input  logic [COL_W-1:0] col,
	input  logic [VAL_W-1:0] wval,
	output pcs_op_t          op,
	output logic [AW-1:0]    even_addr,
	output logic [AW-1:0]    odd_addr
);

	localparam int ROW_LIM = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
	localparam int COL_LIM = (MAX_COLS > 127) ? 127 : MAX_COLS;
	localparam int LIN_W   = ROW_W + CNT_W + 1;
	localparam int ST_W    = LIN_W + 2;
	localparam int IDX_W   = ST_W - 3;

	logic [CNT_W-1:0] r_eff;
	logic [CNT_W-1:0] c_eff;
	logic [2:0]       tot_lo;
	logic [2:0]       pad;
	logic [LIN_W-1:0] lin;
	logic [ST_W-1:0]  start;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] idx_p1;

	always_comb begin
		r_eff  = (int'(row_count) > ROW_LIM) ? CNT_W'(ROW_LIM) : row_count;
		c_eff  = (int'(col_count) > COL_LIM) ? CNT_W'(COL_LIM) : col_count;
		// only the low three bits of 3*R*C set the pad
		tot_lo = 3'(3'(r_eff[2:0] * c_eff[2:0]) * 3'd3);
		pad    = 3'(3'd0 - tot_lo);
		lin    = LIN_W'(row) * LIN_W'(c_eff) + LIN_W'(col);
		start  = ST_W'(pad) + ST_W'({lin, 1'b0}) + ST_W'(lin);
		idx    = start[ST_W-1:3];
		idx_p1 = idx + IDX_W'(1);

		op.oor     = ({1'b0, row} >= r_eff) || ({1'b0, col} >= c_eff);
		op.action  = action;
		op.wval    = wval;
		op.off     = start[2:0];
		op.idx_odd = idx[0];
		op.lo_ok   = int'(idx_p1) < STORE_BYTES;

		// byte idx and idx+1 always fall in opposite banks
		even_addr = AW'(idx_p1 >> 1);
		odd_addr  = AW'(idx >> 1);
	end

endmodule

// ===== src/pcs_ram.sv =====
// Single-port byte RAM, registered read, one bank of the cell store.
`timescale 1ns / 1ps
module pcs_ram #(
	parameter int DEPTH = 769,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	input  logic          we,
	input  logic [7:0]    wdata,
	input  logic          re,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== src/packed_3bit_cell_store_core.sv =====
// Top level of the packed 3-bit cell store: control, banks and result register.
`timescale 1ns / 1ps
// Grid of 3-bit cells packed MSB first into a byte store, pad bits at the start.
// s_axis carries one access word: tuser selects read (0) or write (1), tdata
// holds row, column and the value to store. m_axis returns one word per access:
// the read value in tdata and the out-of-range flag in tuser.
// The cfg channel sets row_count (index 0) and col_count (index 1); it is
// always ready and must only be written while no access is in flight.
// Timing: the bank reads issue in the cycle an access is taken; in the cycle after,
// the bytes are merged, written back and the result loaded once the output is free.
// The result passes the merge state and output register; no new access is taken
// until the last leaves the merge step, set by the banks' read-modify-write.
// The store is split into an even-byte and an odd-byte bank so both bytes
// of a straddling cell are read and written in the same cycle.
// After reset a clearing pass zeroes all STORE_BYTES/2+1 entries of both banks
// (769 at the default size), with s_axis_tready low.
// When m_axis stalls the finished word waits in the output register; one more
// access is taken and holds in the merge step until the output frees.
module packed_3bit_cell_store_core import pcs_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,  // row[5:0], col[11:6], write_value[14:12], zero
	input  logic                 s_axis_tuser,  // action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,  // read_value[2:0], zero
	output logic                 m_axis_tuser,  // out_of_range
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	localparam int STORE_BYTES = (3 * MAX_ROWS * MAX_COLS + 7) / 8;
	localparam int BANK_DEPTH  = STORE_BYTES / 2 + 1;
	localparam int AW          = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic [CNT_W-1:0] row_count_q;
	logic [CNT_W-1:0] col_count_q;

	pcs_op_t       op_in;
	pcs_op_t       op_s1;
	logic [AW-1:0] even_addr_in, odd_addr_in;
	logic [AW-1:0] even_addr_s1, odd_addr_s1;

	logic          accept;
	logic          out_free;
	logic          out_load;
	logic          rd_issue;
	logic [AW-1:0] even_addr, odd_addr;
	logic          even_we, odd_we;
	logic [7:0]    even_wdata, odd_wdata;
	logic [7:0]    even_rdata, odd_rdata;

	logic [7:0]       hi_byte, lo_byte;
	logic [15:0]      word, new_word;
	logic [3:0]       sh;
	logic [VAL_W-1:0] rd_val;
	logic [VAL_W-1:0] read_value;
	logic             do_wr, hi_we, lo_we;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign out_load      = (state_q == ST_MOD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_ROW_COUNT) begin
				row_count_q <= cfg_data;
			end else if (cfg_index == CFG_COL_COUNT) begin
				col_count_q <= cfg_data;
			end
		end
	end

	pcs_addr #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.STORE_BYTES (STORE_BYTES),
		.AW          (AW)
	) u_addr (
		.row_count (row_count_q),
		.col_count (col_count_q),
		.action    (s_axis_tuser),
		.row       (s_axis_tdata[5:0]),
		.col       (s_axis_tdata[11:6]),
		.wval      (s_axis_tdata[14:12]),
		.op        (op_in),
		.even_addr (even_addr_in),
		.odd_addr  (odd_addr_in)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= op_in;
			even_addr_s1 <= even_addr_in;
			odd_addr_s1  <= odd_addr_in;
		end
	end

	// merge of the two read bytes and the write-back word
	always_comb begin
		hi_byte  = op_s1.idx_odd ? odd_rdata : even_rdata;
		lo_byte  = op_s1.lo_ok ? (op_s1.idx_odd ? even_rdata : odd_rdata) : 8'h00;
		word     = {hi_byte, lo_byte};
		sh       = WIN_TOP - {1'b0, op_s1.off};
		rd_val   = VAL_W'(word >> sh);
		new_word = (word & ~(16'(CELL_MASK) << sh)) | (16'(op_s1.wval) << sh);

		read_value = (op_s1.action == ACT_READ && !op_s1.oor) ? rd_val : '0;

		do_wr = (state_q == ST_MOD) && out_free && (op_s1.action == ACT_WRITE) && !op_s1.oor;
		hi_we = do_wr;
		lo_we = do_wr && (op_s1.off > LAST_ONE_BYTE_OFF) && op_s1.lo_ok;
	end

	always_comb begin
		rd_issue = accept && !op_in.oor;
		case (state_q)
			ST_CLEAR: begin
				even_addr  = clr_q;
				odd_addr   = clr_q;
				even_we    = 1'b1;
				odd_we     = 1'b1;
				even_wdata = 8'h00;
				odd_wdata  = 8'h00;
			end
			ST_MOD: begin
				even_addr  = even_addr_s1;
				odd_addr   = odd_addr_s1;
				even_we    = op_s1.idx_odd ? lo_we : hi_we;
				odd_we     = op_s1.idx_odd ? hi_we : lo_we;
				even_wdata = op_s1.idx_odd ? new_word[7:0] : new_word[15:8];
				odd_wdata  = op_s1.idx_odd ? new_word[15:8] : new_word[7:0];
			end
			default: begin
				even_addr  = even_addr_in;
				odd_addr   = odd_addr_in;
				even_we    = 1'b0;
				odd_we     = 1'b0;
				even_wdata = 8'h00;
				odd_wdata  = 8'h00;
			end
		endcase
	end

	pcs_ram #(
		.DEPTH (BANK_DEPTH),
		.AW    (AW)
	) u_even (
		.clk   (clk),
		.addr  (even_addr),
		.we    (even_we),
		.wdata (even_wdata),
		.re    (rd_issue),
		.rdata (even_rdata)
	);

	pcs_ram #(
		.DEPTH (BANK_DEPTH),
		.AW    (AW)
	) u_odd (
		.clk   (clk),
		.addr  (odd_addr),
		.we    (odd_we),
		.wdata (odd_wdata),
		.re    (rd_issue),
		.rdata (odd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && !out_load) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(BANK_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= 8'(read_value);
						m_axis_tuser  <= op_s1.oor;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/pcs_checker.sv =====
// Port-level checks of the packed cell store, bound to the top level.
`timescale 1ns / 1ps
`include "packed_3bit_cell_store_core_macros.svh"
module pcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser
);

	logic s_acc;
	logic m_stall;

	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign m_stall = m_axis_tvalid && !m_axis_tready;

	`PCS_ASSERT_NEXT(a_out_hold, m_stall,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled result word changed")
	`PCS_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_axis_tready,
		"access taken on consecutive cycles")
	`PCS_ASSERT(a_oor_reads_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'h00,
		"out-of-range result carries nonzero data")
	`PCS_ASSERT(a_result_latency, s_acc && !m_axis_tvalid, ##2 m_axis_tvalid,
		"result not delivered two cycles after access")

endmodule

bind packed_3bit_cell_store_core pcs_checker u_pcs_checker (.*);

// ===== test/cell_access_checker.sv =====
// Checker for the packed 3-bit cell store: tracks the byte store and compares every result word.
`timescale 1ns / 1ps
module cell_access_checker import pcs_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [7:0]           m_axis_tdata,
	input  logic                 m_axis_tuser,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   outstanding
);

	localparam int STORE_BYTES = (3 * MAX_ROWS * MAX_COLS + 7) / 8;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             oor;
	} cell_result_t;

	logic [7:0]       cell_bytes [STORE_BYTES];
	logic [CNT_W-1:0] rows_cfg;
	logic [CNT_W-1:0] cols_cfg;
	cell_result_t     due_results [$];
	int               mismatches;

	function automatic logic [7:0] byte_or_zero(int unsigned idx);
		return (idx < STORE_BYTES) ? cell_bytes[idx] : 8'h00;
	endfunction

	// reads or writes one cell and returns the word the block should send back
	function automatic cell_result_t access_cell(logic act, logic [ROW_W-1:0] r,
			logic [COL_W-1:0] c, logic [VAL_W-1:0] v);
		cell_result_t res;
		int unsigned  nr, nc, total, nbytes, pad, start, idx, off, sh;
		logic [15:0]  win, mask, sel;
		res = '0;
		nr = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
		nc = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
		if (r >= nr || c >= nc) begin
			res.oor = 1'b1;
			return res;
		end
		total  = 3 * nr * nc;
		nbytes = (total + 7) / 8;
		pad    = nbytes * 8 - total;
		start  = pad + 3 * (r * nc + c);
		idx    = start >> 3;
		off    = start & 7;
		sh     = WIN_TOP - off;
		win    = {byte_or_zero(idx), byte_or_zero(idx + 1)};
		if (act == ACT_READ) begin
			sel = win >> sh;
			res.value = sel[VAL_W-1:0] & CELL_MASK;
		end else begin
			mask = {13'b0, CELL_MASK} << sh;
			win  = (win & ~mask) | ({13'b0, v} << sh);
			if (idx < STORE_BYTES)
				cell_bytes[idx] = win[15:8];
			// cell spills into the next byte
			if (off > LAST_ONE_BYTE_OFF && idx + 1 < STORE_BYTES)
				cell_bytes[idx + 1] = win[7:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		cell_result_t want;
		if (!arst_n) begin
			foreach (cell_bytes[i])
				cell_bytes[i] = 8'h00;
			rows_cfg = ROW_COUNT_RST;
			cols_cfg = COL_COUNT_RST;
			due_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ROW_COUNT)
					rows_cfg = cfg_data;
				else if (cfg_index == CFG_COL_COUNT)
					cols_cfg = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					$error("result word with no access pending: read_value %0d out_of_range %0d",
						m_axis_tdata[VAL_W-1:0], m_axis_tuser);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (m_axis_tdata[VAL_W-1:0] !== want.value) begin
						$error("read_value mismatch: expected %0d, got %0d",
							want.value, m_axis_tdata[VAL_W-1:0]);
						mismatches++;
					end
					if (m_axis_tuser !== want.oor) begin
						$error("out_of_range mismatch: expected %0d, got %0d",
							want.oor, m_axis_tuser);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				due_results.push_back(access_cell(s_axis_tuser, s_axis_tdata[5:0],
					s_axis_tdata[11:6], s_axis_tdata[14:12]));
		end
		fail_count  <= mismatches;
		outstanding <= due_results.size();
	end

endmodule

// ===== test/tb.sv =====
// Testbench top for the packed 3-bit cell store: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb import pcs_pkg::*;;

	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata  = '0;
	logic                 s_axis_tuser  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CNT_W-1:0]     cfg_data      = '0;

	int          fail_count;
	int          outstanding;
	int          cycle_count = 0;
	int unsigned burst_left  = 0;
	bit          hold_req    = 1'b0;

	always #4 clk = ~clk;

	packed_3bit_cell_store_core #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cell_access_checker #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random ready pattern, plus one long hold on request
	initial begin : sink
		int unsigned run;
		int unsigned mode;
		bit          hold_seen;
		hold_seen = 1'b0;
		forever begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					m_axis_tready <= 1'b0;
					@(posedge clk);
				end
			end else begin
				mode = $urandom_range(0, 3);
				run  = (mode == 2) ? $urandom_range(1, 8) : $urandom_range(1, 40);
				for (int i = 0; i < run; i++) begin
					case (mode)
						1: m_axis_tready <= ($urandom_range(0, 2) != 0);
						2: m_axis_tready <= 1'b0;
						default: m_axis_tready <= 1'b1;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// one access word; steady skips the random gaps between bursts
	task automatic offer(logic act, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
			logic [VAL_W-1:0] v, bit steady);
		int unsigned gap;
		if (!steady) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				burst_left = $urandom_range(1, 24);
				if (gap != 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {1'b0, v, c, r};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drop tvalid and wait on the clock first so the count includes the last accepted word
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_grid(int unsigned rows, int unsigned cols);
		wait_idle();
		write_reg(CFG_ROW_COUNT, rows[CNT_W-1:0]);
		write_reg(CFG_COL_COUNT, cols[CNT_W-1:0]);
		cfg_valid <= 1'b0;
	endtask

	// edges, a window of cells that sees repeated traffic, and some out of range
	function automatic logic [5:0] pick_coord(int unsigned lim, int unsigned base);
		int unsigned v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = (lim == 0) ? 0 : lim - 1;
			2: v = lim;
			3: v = $urandom_range(0, 63);
			4, 5, 6: v = (lim == 0) ? $urandom_range(0, 63) : $urandom_range(0, lim - 1);
			default: v = base + $urandom_range(0, 3);
		endcase
		if (v > 63)
			v = 63;
		return v[5:0];
	endfunction

	task automatic run_phase(int unsigned rows, int unsigned cols, int unsigned n, bit flood);
		int unsigned lim_r, lim_c, base_r, base_c;
		set_grid(rows, cols);
		lim_r  = (rows > MAX_ROWS) ? MAX_ROWS : rows;
		lim_c  = (cols > MAX_COLS) ? MAX_COLS : cols;
		base_r = (lim_r > 4) ? $urandom_range(0, lim_r - 4) : 0;
		base_c = (lim_c > 4) ? $urandom_range(0, lim_c - 4) : 0;
		if (flood)
			hold_req = ~hold_req;
		for (int i = 0; i < n; i++)
			offer(1'($urandom_range(0, 1)), pick_coord(lim_r, base_r),
				pick_coord(lim_c, base_c), 3'($urandom_range(0, 7)), flood && i < 60);
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// default 8x8 grid, no pad bits
		offer(ACT_READ,  0, 0, 0, 0);
		offer(ACT_WRITE, 0, 0, 7, 0);
		offer(ACT_WRITE, 0, 1, 5, 0);
		offer(ACT_WRITE, 2, 5, 3, 0);
		offer(ACT_READ,  2, 5, 0, 0);
		offer(ACT_READ,  2, 4, 0, 0);
		offer(ACT_READ,  2, 6, 0, 0);
		offer(ACT_READ,  0, 0, 0, 0);
		offer(ACT_READ,  0, 1, 0, 0);
		offer(ACT_WRITE, 7, 7, 6, 0);
		offer(ACT_READ,  7, 7, 0, 0);
		offer(ACT_WRITE, 8, 0, 7, 0);
		offer(ACT_READ,  0, 8, 0, 0);
		offer(ACT_WRITE, 63, 63, 7, 0);
		offer(ACT_READ,  63, 63, 0, 0);

		// 3x5 grid has three pad bits; old bytes read back under the new layout
		set_grid(3, 5);
		offer(ACT_READ,  0, 0, 0, 0);
		offer(ACT_WRITE, 0, 0, 5, 0);
		offer(ACT_READ,  0, 0, 0, 0);
		offer(ACT_WRITE, 2, 4, 7, 0);
		offer(ACT_READ,  2, 4, 0, 0);
		offer(ACT_READ,  2, 5, 0, 0);

		wait_idle();
		write_reg(CFG_UNMAPPED, 7'h7F);
		cfg_valid <= 1'b0;
		offer(ACT_READ,  2, 4, 0, 0);
		offer(ACT_READ,  3, 0, 0, 0);

		run_phase(64, 64, 140, 1);
		run_phase(1, 1, 60, 0);
		run_phase(0, 7, 30, 0);
		run_phase(127, 127, 120, 0);
		run_phase(1, 64, 100, 0);
		run_phase(64, 1, 100, 0);
		run_phase(3, 5, 100, 0);
		run_phase(13, 11, 100, 0);
		run_phase(5, 0, 30, 0);
		for (int p = 0; p < 3; p++)
			run_phase($urandom_range(1, 64), $urandom_range(1, 64), 100, 0);

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
